>>> hw/rtl/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared constants, codes, kernel taps and the queue item type of the 3x3
// image filter.
// ----------------------------------------------------------------------------
package conv3_pkg;

  localparam int PIX_W           = 8;
  localparam int CFG_W           = 13;
  localparam int IDX_W           = 2;
  localparam int WIDTH_FIELD_W   = 12;
  localparam int HEIGHT_FIELD_W  = 13;
  localparam int KSEL_W          = 4;
  localparam int H_W             = 13;   // holds 3..4096
  localparam int ROW_W           = 12;
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT      = 4096;
  localparam int MIN_DIM         = 3;
  localparam int WIDTH_RST       = 640;
  localparam int HEIGHT_RST      = 480;
  localparam int KSEL_RST        = 4;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int TAPS            = 9;
  localparam int TAP_W           = 4;
  localparam int COEF_W          = 5;
  localparam int PROD_W          = 14;
  localparam int SUM_W           = 17;
  localparam int PIX_MAX         = 255;
  // Blur taps are {1,2,1,2,4,2,1,2,1}, summing to 16; dividing by 16 is a shift by 4.
  localparam int BLUR_SHIFT      = 4;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2
  } cfg_reg_t;

  typedef enum logic [KSEL_W-1:0] {
    K_BLUR         = 4'd1,
    K_SOBEL_TOP    = 4'd2,
    K_EMBOSS       = 4'd3,
    K_IDENTITY     = 4'd4,
    K_SOBEL_LEFT   = 4'd5,
    K_OUTLINE      = 4'd6,
    K_SOBEL_RIGHT  = 4'd7,
    K_SHARPEN      = 4'd8,
    K_SOBEL_BOTTOM = 4'd9
  } kernel_t;

  // Entry k holds the taps of kernel k; window order is top row first.
  localparam logic signed [COEF_W-1:0] KERNEL_TAPS [1:9][0:8] = '{
    '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
    '{ 5'sd1,  5'sd2,  5'sd1,  5'sd0,  5'sd0,  5'sd0, -5'sd1, -5'sd2, -5'sd1},
    '{-5'sd2, -5'sd1,  5'sd0, -5'sd1,  5'sd1,  5'sd1,  5'sd0,  5'sd1,  5'sd2},
    '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{ 5'sd1,  5'sd0, -5'sd1,  5'sd2,  5'sd0, -5'sd2,  5'sd1,  5'sd0, -5'sd1},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{-5'sd1,  5'sd0,  5'sd1, -5'sd2,  5'sd0,  5'sd2, -5'sd1,  5'sd0,  5'sd1},
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{-5'sd1, -5'sd2, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd2,  5'sd1}
  };

  // Unknown selects give an all-zero kernel.
  function automatic logic signed [COEF_W-1:0] kernel_coef(
    input logic [KSEL_W-1:0] sel,
    input logic [TAP_W-1:0]  tap
  );
    logic signed [COEF_W-1:0] c;
    c = '0;
    if ((sel >= KSEL_W'(K_BLUR)) && (sel <= KSEL_W'(K_SOBEL_BOTTOM))) begin
      c = KERNEL_TAPS[sel][tap];
    end
    return c;
  endfunction

  typedef struct packed {
    logic             shift;      // pixel item: moves the window
    logic             emit;       // gives a result
    logic             zero;       // result is a border zero
    logic             frame_end;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;
  } item_t;

endpackage

>>> hw/rtl/conv3_in_if.sv
// ----------------------------------------------------------------------------
// conv3_in_if
// Pixel input channel: valid/ready with mode and pixel payload.
// ----------------------------------------------------------------------------
interface conv3_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [conv3_pkg::PIX_W-1:0]   pixel_in;

  modport source (output valid, mode, pixel_in, input ready);
  modport sink   (input valid, mode, pixel_in, output ready);
endinterface

>>> hw/rtl/conv3_out_if.sv
// ----------------------------------------------------------------------------
// conv3_out_if
// Filtered output channel: valid/ready with pixel and frame end marker.
// ----------------------------------------------------------------------------
interface conv3_out_if;
  logic                          valid;
  logic                          ready;
  logic [conv3_pkg::PIX_W-1:0]   pixel_out;
  logic                          frame_end;

  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink   (input valid, pixel_out, frame_end, output ready);
endinterface

>>> hw/rtl/conv3_front.sv
// ----------------------------------------------------------------------------
// conv3_front
// Config registers, raster position counters, line stores and item
// classification. Pushes one queue item per pixel or emitting drain tick.
// ----------------------------------------------------------------------------
module conv3_front #(
  parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF,
  parameter int QDEPTH    = conv3_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W    = $clog2(QDEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [conv3_pkg::IDX_W-1:0]    cfg_index,
  input  logic [conv3_pkg::CFG_W-1:0]    cfg_data,
  conv3_in_if.sink                       pixels,
  input  logic [CNT_W-1:0]               q_count,
  output logic                           q_push,
  output conv3_pkg::item_t               q_item,
  output logic [conv3_pkg::KSEL_W-1:0]   kernel_select,
  output logic                           restart
);
  import conv3_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int TOT_W = WW + H_W;
  localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

  function automatic logic [WW-1:0] sat_width(input logic [WIDTH_FIELD_W-1:0] v);
    logic [WW-1:0] r;
    if (32'(v) < MIN_DIM) r = WW'(MIN_DIM);
    else if (32'(v) > MAX_WIDTH) r = WW'(MAX_WIDTH);
    else r = WW'(v);
    return r;
  endfunction

  function automatic logic [H_W-1:0] sat_height(input logic [HEIGHT_FIELD_W-1:0] v);
    logic [H_W-1:0] r;
    if (32'(v) < MIN_DIM) r = H_W'(MIN_DIM);
    else if (32'(v) > MAX_HEIGHT) r = H_W'(MAX_HEIGHT);
    else r = H_W'(v);
    return r;
  endfunction

  logic [WW-1:0]    width_eff, width_new;
  logic [H_W-1:0]   height_eff, height_new;
  logic [TOT_W-1:0] total;
  logic             cfg_hit;

  logic [AW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [TOT_W-1:0] given, given_inc;
  logic [AW:0]      col_inc;
  logic [ROW_W:0]   row_inc;
  logic             take, own, pending, interior, emit, is_drain;
  logic             given_wrap, col_wrap, row_wrap;

  logic [PIX_W-1:0] line_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_b [MAX_WIDTH];
  logic [PIX_W-1:0] rd_a, rd_b;

  logic             s1_valid, s1_shift, s1_emit, s1_zero, s1_fe;
  logic [PIX_W-1:0] s1_pix;
  logic [AW-1:0]    s1_addr;

  // ---- configuration ----
  always_comb begin
    width_new  = width_eff;
    height_new = height_eff;
    cfg_hit    = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          cfg_hit   = 1'b1;
          width_new = sat_width(cfg_data[WIDTH_FIELD_W-1:0]);
        end
        REG_HEIGHT: begin
          cfg_hit    = 1'b1;
          height_new = sat_height(cfg_data[HEIGHT_FIELD_W-1:0]);
        end
        REG_KERNEL: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff     <= WW'(W_RST);
      height_eff    <= H_W'(HEIGHT_RST);
      kernel_select <= KSEL_W'(KSEL_RST);
      total         <= TOT_W'(W_RST * HEIGHT_RST);
    end else if (cfg_hit) begin
      width_eff  <= width_new;
      height_eff <= height_new;
      total      <= TOT_W'(width_new) * TOT_W'(height_new);
      if (cfg_index == REG_KERNEL) begin
        kernel_select <= cfg_data[KSEL_W-1:0];
      end
    end
  end

  assign restart = cfg_hit;

  // ---- classification ----
  always_comb begin
    is_drain   = (pixels.mode == MODE_DRAIN);
    take       = pixels.valid && pixels.ready;
    own        = (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && (col != '0));
    interior   = (row >= ROW_W'(2)) && (col >= AW'(2));
    pending    = (given != '0);
    emit       = is_drain ? (!own && pending) : (own || pending);
    given_inc  = given + 1'b1;
    given_wrap = (given_inc >= total);
    col_inc    = {1'b0, col} + 1'b1;
    col_wrap   = (32'(col_inc) >= 32'(width_eff));
    row_inc    = {1'b0, row} + 1'b1;
    row_wrap   = (row_inc >= height_eff);
  end

  // Room is kept for the item in flight to the queue, so stage 1 never stalls.
  assign pixels.ready = !rst &&
      (((CNT_W + 1)'(q_count) + (CNT_W + 1)'(s1_valid)) < (CNT_W + 1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col   <= '0;
      row   <= '0;
      given <= '0;
    end else if (take) begin
      if (emit) begin
        given <= given_wrap ? '0 : given_inc;
      end
      if (!is_drain) begin
        if (col_wrap) begin
          col <= '0;
          row <= row_wrap ? '0 : row_inc[ROW_W-1:0];
        end else begin
          col <= col_inc[AW-1:0];
        end
      end
    end
  end

  // ---- line stores: read old row data, store B in the next cycle ----
  always_ff @(posedge clk) begin
    rd_a <= line_a[col];
    if (take && !is_drain) begin
      line_a[col] <= pixels.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    rd_b <= line_b[col];
    if (s1_valid && s1_shift) begin
      line_b[s1_addr] <= rd_a;
    end
  end

  // ---- stage 1: line store data arrives ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take && (!is_drain || emit);
    end
  end

  always_ff @(posedge clk) begin
    s1_shift <= !is_drain;
    s1_emit  <= emit;
    s1_zero  <= is_drain || !interior;
    s1_fe    <= given_wrap;
    s1_pix   <= pixels.pixel_in;
    s1_addr  <= col;
  end

  always_comb begin
    q_push           = s1_valid;
    q_item.shift     = s1_shift;
    q_item.emit      = s1_emit;
    q_item.zero      = s1_zero;
    q_item.frame_end = s1_fe;
    q_item.pix       = s1_pix;
    q_item.up1       = rd_a;
    q_item.up2       = rd_b;
  end

endmodule

>>> hw/rtl/conv3_queue.sv
// ----------------------------------------------------------------------------
// conv3_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module conv3_queue #(
  parameter int DEPTH  = conv3_pkg::QUEUE_DEPTH_DEF,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  conv3_pkg::item_t  push_item,
  input  logic              pop,
  output logic              valid,
  output conv3_pkg::item_t  head_item,
  output logic [CNT_W-1:0]  count
);
  import conv3_pkg::*;

  item_t         slots [DEPTH];
  logic [PW-1:0] rd_ptr, wr_ptr;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_next(wr_ptr);
      if (pop)  rd_ptr <= ptr_next(rd_ptr);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign valid     = (count != '0);
  assign head_item = slots[rd_ptr];

endmodule

>>> hw/rtl/conv3_back.sv
// ----------------------------------------------------------------------------
// conv3_back
// Window shift, tap products, sum, scale and clamp, and the output register.
// ----------------------------------------------------------------------------
module conv3_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [conv3_pkg::KSEL_W-1:0]  kernel_select,
  input  logic                          q_valid,
  input  conv3_pkg::item_t              q_item,
  output logic                          q_pop,
  conv3_out_if.source                   filtered
);
  import conv3_pkg::*;

  logic [PIX_W-1:0]         window   [TAPS];
  logic [PIX_W-1:0]         win_next [TAPS];
  logic signed [PROD_W-1:0] prod     [TAPS];

  logic p_valid, p_emit, p_zero, p_fe, p_blur;
  logic p_free, o_free;

  logic                     out_valid, out_fe;
  logic [PIX_W-1:0]         out_pix;
  logic signed [SUM_W-1:0]  sum, scaled;
  logic [PIX_W-1:0]         clamped;

  assign o_free = !out_valid || filtered.ready;
  assign p_free = !p_valid || o_free;
  assign q_pop  = q_valid && p_free;

  // New column enters on the right: top from two rows up, bottom is the pixel.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[3*r]     = window[3*r + 1];
      win_next[3*r + 1] = window[3*r + 2];
    end
    win_next[2] = q_item.up2;
    win_next[5] = q_item.up1;
    win_next[8] = q_item.pix;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int k = 0; k < TAPS; k++) window[k] <= '0;
    end else if (q_pop && q_item.shift) begin
      for (int k = 0; k < TAPS; k++) window[k] <= win_next[k];
    end
  end

  // ---- product stage ----
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_free) begin
      p_emit <= q_item.emit;
      p_zero <= q_item.zero;
      p_fe   <= q_item.frame_end;
      p_blur <= (kernel_select == KSEL_W'(K_BLUR));
      for (int k = 0; k < TAPS; k++) begin
        prod[k] <= PROD_W'($signed({1'b0, win_next[k]})) *
                   PROD_W'(kernel_coef(kernel_select, TAP_W'(k)));
      end
    end
  end

  // ---- sum, scale, clamp ----
  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + SUM_W'(prod[k]);
    end
    scaled = p_blur ? (sum >>> BLUR_SHIFT) : sum;
    if (p_zero || (scaled < 0)) begin
      clamped = '0;
    end else if (scaled > SUM_W'(PIX_MAX)) begin
      clamped = PIX_W'(PIX_MAX);
    end else begin
      clamped = scaled[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= p_valid && p_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      out_pix <= clamped;
      out_fe  <= p_fe;
    end
  end

  assign filtered.valid     = out_valid;
  assign filtered.pixel_out = out_pix;
  assign filtered.frame_end = out_fe;

endmodule

>>> hw/rtl/conv3x3_image_filter_core.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter_core
// Streaming 3x3 convolution over raster grayscale pixels with two line
// stores, border zeros and trailing drain.
//
//   channel    dir   handshake        payload
//   pixels     in    valid / ready    mode, pixel_in
//   filtered   out   valid / ready    pixel_out, frame_end
//   cfg        in    cfg_wr_en        cfg_index, cfg_data
//
// One item per clock sustained while the output is not stalled; the line
// store read and write ports are used once per pixel item, which sets
// that rate. A result passes, after its item, through the line store
// read, the queue, the product register and the output register.
// rst is synchronous; after it no clearing pass is run, line stores start
// unwritten. A config write to width, height or kernel restarts the frame.
// An output stall backs up the back end first; the input stalls once the
// queue, counting the item in flight to it, is full.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_core #(
  parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF,
  parameter int QDEPTH    = conv3_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [conv3_pkg::IDX_W-1:0]   cfg_index,
  input  logic [conv3_pkg::CFG_W-1:0]   cfg_data,
  conv3_in_if.sink                      pixels,
  conv3_out_if.source                   filtered
);
  import conv3_pkg::*;

  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic              q_push, q_pop, q_valid, restart;
  item_t             q_push_item, q_head_item;
  logic [CNT_W-1:0]  q_count;
  logic [KSEL_W-1:0] kernel_select;

  conv3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .QDEPTH    (QDEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixels        (pixels),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_item        (q_push_item),
    .kernel_select (kernel_select),
    .restart       (restart)
  );

  conv3_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_item (q_head_item),
    .count     (q_count)
  );

  conv3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .kernel_select (kernel_select),
    .q_valid       (q_valid),
    .q_item        (q_head_item),
    .q_pop         (q_pop),
    .filtered      (filtered)
  );

  // ---- assertions ----
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
      (q_push && !q_pop) |-> (32'(q_count) < QDEPTH))
    else $error("queue push while full");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
      q_pop |-> (q_count != '0))
    else $error("queue pop while empty");

  // The last result of a frame is always a bottom row border pixel.
  a_frame_end_is_border: assert property (@(posedge clk) disable iff (rst)
      (filtered.valid && filtered.frame_end) |-> (filtered.pixel_out == '0))
    else $error("frame end on a nonzero pixel");

endmodule
